[design/pwa_pkg.sv]
// Package for the periodic wavelet analysis block.
// Holds field widths, register codes, state, command and status types, and the
// output rounding function. No dependencies.
package pwa_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W        = 40;
    localparam int OUT_FRAC     = 15;
    localparam int OUT_W        = 20;
    localparam int OUT_IDX_W    = 6;
    localparam int COEF_IDX_W   = 5;
    localparam int FILL_W       = 8;

    localparam int TAPCNT_W     = 6;
    localparam int PHASE_W      = 6;
    localparam int LEN_W        = 3;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LOG2  = 2'd2;

    localparam logic [TAPCNT_W-1:0] TAPCNT_RST = 6'd4;
    localparam logic [PHASE_W-1:0]  PHASE_RST  = 6'd0;
    localparam logic [LEN_W-1:0]    LEN_RST    = 3'd7;

    // input item mode codes
    localparam logic MODE_COEF   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // product fraction bits minus output fraction bits
    localparam int SH = (SAMPLE_WIDTH - 1) + (COEF_WIDTH - 1) - OUT_FRAC;
    localparam int QW = ACC_W - SH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAIR,
        ST_MAC,
        ST_DRAIN
    } t_pwa_state;

    typedef struct packed {
        logic in_ready;
        logic pair_init;
        logic mac_issue;
        logic finish;
    } t_pwa_cmd;

    typedef struct packed {
        logic vec_done;
        logic taps_zero;
        logic k_last;
        logic j_last;
        logic pipe_busy;
        logic out_free;
    } t_pwa_status;

    // round half up to OUT_FRAC fraction bits, then saturate to OUT_W bits
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] v;
        logic signed [QW-1:0]    q;
        logic signed [QW-1:0]    q_max;
        logic signed [QW-1:0]    q_min;
        q_max = QW'((2 ** (OUT_W - 1)) - 1);
        q_min = QW'(-(2 ** (OUT_W - 1)));
        v = acc + (ACC_W'(1) << (SH - 1));
        q = v[ACC_W-1:SH];
        if (q > q_max) begin
            return OUT_W'(q_max);
        end else if (q < q_min) begin
            return OUT_W'(q_min);
        end
        return OUT_W'(q);
    endfunction

endpackage

[design/pwa_in_if.sv]
// Input channel of the wavelet analysis block: valid/ready plus item fields.
// Depends on pwa_pkg for field widths.
interface pwa_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   mode;
    logic [pwa_pkg::COEF_IDX_W-1:0]         coef_index;
    logic signed [pwa_pkg::COEF_WIDTH-1:0]  low_coef;
    logic signed [pwa_pkg::COEF_WIDTH-1:0]  high_coef;
    logic signed [pwa_pkg::SAMPLE_WIDTH-1:0] sample;

    modport source (
        output valid, mode, coef_index, low_coef, high_coef, sample,
        input  ready
    );
    modport sink (
        input  valid, mode, coef_index, low_coef, high_coef, sample,
        output ready
    );
endinterface

[design/pwa_out_if.sv]
// Output channel of the wavelet analysis block: valid/ready plus result pair.
// Depends on pwa_pkg for field widths.
interface pwa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pwa_pkg::OUT_W-1:0]    low_out;
    logic signed [pwa_pkg::OUT_W-1:0]    high_out;
    logic [pwa_pkg::OUT_IDX_W-1:0]       out_index;
    logic                                last_out;

    modport source (
        output valid, low_out, high_out, out_index, last_out,
        input  ready
    );
    modport sink (
        input  valid, low_out, high_out, out_index, last_out,
        output ready
    );
endinterface

[design/periodic_wavelet_analysis.sv]
// One level of a periodic wavelet analysis filter bank. Coefficient items
// (mode 0) load a low/high tap pair; sample items (mode 1) are written into
// the vector store one per cycle. The sample that completes a vector of
// n = 2^length_log2 samples (0 counts as 1; n at most MAX_LEN) starts the
// MAC engine, and no item is taken until all n/2 pairs have been computed
// and handed to the output register. The engine is one low/high MAC pair
// per cycle on sample and tap memories with registered reads; each pair is
// a setup step, a step for each tap (tap_count capped at MAX_TAPS, none when
// it is zero), then a drain of the three-stage pipe. A stalled output holds
// the engine before the next pair.
// Depends on pwa_pkg, pwa_in_if, pwa_out_if, pwa_ctrl and pwa_dp.
module periodic_wavelet_analysis #(
    parameter int MAX_LEN  = 128,
    parameter int MAX_TAPS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pwa_in_if.sink                         i_in,
    pwa_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [pwa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pwa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pwa_pkg::t_pwa_cmd    cmd;
    pwa_pkg::t_pwa_status status;

    pwa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pwa_dp #(
        .MAX_LEN  (MAX_LEN),
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

[design/pwa_ctrl.sv]
// Sequencer for the wavelet analysis block: steps pairs and taps.
// Depends on pwa_pkg for state, command and status types.
module pwa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pwa_pkg::t_pwa_status i_status,
    output pwa_pkg::t_pwa_cmd    o_cmd
);

    pwa_pkg::t_pwa_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pwa_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.vec_done) begin
                    n_state = pwa_pkg::ST_PAIR;
                end
            end
            pwa_pkg::ST_PAIR: begin
                o_cmd.pair_init = 1'b1;
                n_state = i_status.taps_zero ? pwa_pkg::ST_DRAIN : pwa_pkg::ST_MAC;
            end
            pwa_pkg::ST_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (i_status.k_last) begin
                    n_state = pwa_pkg::ST_DRAIN;
                end
            end
            pwa_pkg::ST_DRAIN: begin
                // sums complete once the MAC pipe is empty
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = i_status.j_last ? pwa_pkg::ST_IDLE : pwa_pkg::ST_PAIR;
                end
            end
            default: begin
                n_state = pwa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/pwa_dp.sv]
// Datapath of the wavelet analysis block: config registers, sample and tap
// memories, address generation, MAC pipe and output register.
// Depends on pwa_pkg, pwa_in_if and pwa_out_if.
module pwa_dp #(
    parameter int MAX_LEN  = 128,
    parameter int MAX_TAPS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pwa_in_if.sink                           i_in,
    pwa_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [pwa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pwa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  pwa_pkg::t_pwa_cmd                i_cmd,
    output pwa_pkg::t_pwa_status             o_status
);

    localparam int SW  = pwa_pkg::SAMPLE_WIDTH;
    localparam int CW  = pwa_pkg::COEF_WIDTH;
    localparam int AW  = $clog2(MAX_LEN + 1) - 1;   // log2 of largest usable length
    localparam int TW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCW = $clog2(MAX_TAPS + 1);
    localparam int FW  = pwa_pkg::FILL_W;

    // configuration
    logic [pwa_pkg::TAPCNT_W-1:0] r_tap_count;
    logic [pwa_pkg::PHASE_W-1:0]  r_phase;
    logic [pwa_pkg::LEN_W-1:0]    r_len_log2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= pwa_pkg::TAPCNT_RST;
            r_phase     <= pwa_pkg::PHASE_RST;
            r_len_log2  <= pwa_pkg::LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pwa_pkg::CFG_TAP_COUNT:    r_tap_count <= i_cfg_data;
                pwa_pkg::CFG_PHASE_OFFSET: r_phase     <= i_cfg_data;
                pwa_pkg::CFG_LENGTH_LOG2:  r_len_log2  <= i_cfg_data[pwa_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective length and tap count
    logic [pwa_pkg::LEN_W-1:0] lg1, eff_lg;
    logic [AW-1:0]             mask, half_m1;
    logic [FW-1:0]             len_n;
    logic [TCW-1:0]            taps_eff, taps_m1;

    always_comb begin
        lg1     = (r_len_log2 == '0) ? pwa_pkg::LEN_W'(1) : r_len_log2;
        eff_lg  = (lg1 > pwa_pkg::LEN_W'(AW)) ? pwa_pkg::LEN_W'(AW) : lg1;
        len_n   = FW'(1) << eff_lg;
        mask    = AW'(len_n - FW'(1));
        half_m1 = mask >> 1;
        taps_eff = ({1'b0, r_tap_count} > (pwa_pkg::TAPCNT_W + 1)'(MAX_TAPS))
                 ? TCW'(MAX_TAPS) : TCW'(r_tap_count);
        taps_m1 = taps_eff - TCW'(1);
    end

    // input side
    logic          in_xfer, smp_we, tap_we, vec_done;
    logic [FW-1:0] r_fill, fill_next;
    logic [AW-1:0] smp_waddr;
    logic [TW-1:0] tap_waddr;

    assign i_in.ready = i_cmd.in_ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign smp_we     = in_xfer && (i_in.mode == pwa_pkg::MODE_SAMPLE);
    assign tap_we     = in_xfer && (i_in.mode == pwa_pkg::MODE_COEF)
                     && (32'(i_in.coef_index) < MAX_TAPS);
    assign fill_next  = r_fill + FW'(1);
    // count wrap also completes the vector
    assign vec_done   = smp_we && ((fill_next >= len_n) || (fill_next == '0));
    assign smp_waddr  = AW'(r_fill) & mask;
    assign tap_waddr  = TW'(i_in.coef_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (smp_we) begin
            r_fill <= vec_done ? '0 : fill_next;
        end
    end

    // pair / tap counters
    logic [AW-1:0] r_j;
    logic [TW-1:0] r_k;
    logic [AW-1:0] smp_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
            r_k <= '0;
        end else begin
            if (vec_done) begin
                r_j <= '0;
            end else if (i_cmd.finish) begin
                r_j <= r_j + AW'(1);
            end
            if (i_cmd.pair_init) begin
                r_k <= '0;
            end else if (i_cmd.mac_issue) begin
                r_k <= r_k + TW'(1);
            end
        end
    end

    assign smp_raddr = ((r_j << 1) + AW'(r_k) - AW'(r_phase)) & mask;

    // memories
    logic signed [SW-1:0] r_smp_mem  [1 << AW];
    logic signed [CW-1:0] r_low_mem  [1 << TW];
    logic signed [CW-1:0] r_high_mem [1 << TW];
    logic signed [SW-1:0] r_smp_q;
    logic signed [CW-1:0] r_low_q, r_high_q;

    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            r_smp_mem[smp_waddr] <= i_in.sample;
        end
        r_smp_q <= r_smp_mem[smp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tap_we) begin
            r_low_mem[tap_waddr]  <= i_in.low_coef;
            r_high_mem[tap_waddr] <= i_in.high_coef;
        end
        r_low_q  <= r_low_mem[r_k];
        r_high_q <= r_high_mem[r_k];
    end

    // MAC pipe: read, multiply, accumulate
    logic                              r_v1, r_v2;
    logic signed [pwa_pkg::PROD_W-1:0] r_prod_l, r_prod_h;
    logic signed [pwa_pkg::ACC_W-1:0]  r_acc_l, r_acc_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_l <= r_low_q * r_smp_q;
        r_prod_h <= r_high_q * r_smp_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.pair_init) begin
            r_acc_l <= '0;
            r_acc_h <= '0;
        end else if (r_v2) begin
            r_acc_l <= r_acc_l + pwa_pkg::ACC_W'(r_prod_l);
            r_acc_h <= r_acc_h + pwa_pkg::ACC_W'(r_prod_h);
        end
    end

    // output register
    logic                                r_out_valid;
    logic signed [pwa_pkg::OUT_W-1:0]    r_low_out, r_high_out;
    logic [pwa_pkg::OUT_IDX_W-1:0]       r_out_index;
    logic                                r_last_out;
    logic                                out_free;

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_low_out   <= pwa_pkg::round_sat(r_acc_l);
            r_high_out  <= pwa_pkg::round_sat(r_acc_h);
            r_out_index <= pwa_pkg::OUT_IDX_W'(r_j);
            r_last_out  <= (r_j == half_m1);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.low_out   = r_low_out;
    assign o_out.high_out  = r_high_out;
    assign o_out.out_index = r_out_index;
    assign o_out.last_out  = r_last_out;

    // status to sequencer
    always_comb begin
        o_status.vec_done  = vec_done;
        o_status.taps_zero = (taps_eff == '0);
        o_status.k_last    = (TCW'(r_k) == taps_m1);
        o_status.j_last    = (r_j == half_m1);
        o_status.pipe_busy = r_v1 || r_v2;
        o_status.out_free  = out_free;
    end

endmodule

[dv/periodic_wavelet_analysis_tb.sv]
// Testbench for periodic_wavelet_analysis: directed and random tap loads and sample vectors,
// with a built-in filter bank predictor checking every output pair in order.
// Depends on pwa_pkg, pwa_in_if, pwa_out_if and the block itself.
module periodic_wavelet_analysis_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwa_pkg::*;

    localparam int VEC_MAX       = 128;
    localparam int TAP_MAX       = 32;
    localparam int ROUND_SHIFT   = (SAMPLE_WIDTH - 1) + (COEF_WIDTH - 1) - OUT_FRAC;
    localparam longint OUT_HI    = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_LO    = -(longint'(1) << (OUT_W - 1));
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic                           mode;
        logic [COEF_IDX_W-1:0]          ci;
        logic signed [COEF_WIDTH-1:0]   lc;
        logic signed [COEF_WIDTH-1:0]   hc;
        logic signed [SAMPLE_WIDTH-1:0] smp;
    } stim_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] lo;
        logic signed [OUT_W-1:0] hi;
        logic [OUT_IDX_W-1:0]    idx;
        logic                    last;
    } wpair_t;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pwa_in_if  in_ch ();
    pwa_out_if out_ch ();

    periodic_wavelet_analysis uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic signed [SAMPLE_WIDTH-1:0] vec_mem [VEC_MAX];
    logic signed [COEF_WIDTH-1:0]   lp_tap  [TAP_MAX];
    logic signed [COEF_WIDTH-1:0]   hp_tap  [TAP_MAX];
    logic [FILL_W-1:0]              fill_cnt;
    logic [TAPCNT_W-1:0]            cfg_taps;
    logic [PHASE_W-1:0]             cfg_phase;
    logic [LEN_W-1:0]               cfg_len;

    wpair_t pairs_due [$];
    stim_t  stim_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int items_pushed;
    int items_taken  = 0;
    int coef_loads   = 0;
    int vectors_done = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pairs outstanding",
                     cycle_cnt, pairs_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int vec_len();
        int lg;
        lg = (cfg_len == 0) ? 1 : int'(cfg_len);
        return ((1 << lg) > VEC_MAX) ? VEC_MAX : (1 << lg);
    endfunction

    // round half up to Q5.15, then clamp to the output range
    function automatic logic signed [OUT_W-1:0] to_q5_15(input longint acc);
        longint v;
        v = (acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (v > OUT_HI) v = OUT_HI;
        if (v < OUT_LO) v = OUT_LO;
        return OUT_W'(v);
    endfunction

    function automatic void absorb_item(input stim_t it);
        int     n;
        int     taps;
        int     idx;
        longint lacc;
        longint hacc;
        wpair_t p;
        if (it.mode == MODE_COEF) begin
            lp_tap[it.ci] = it.lc;
            hp_tap[it.ci] = it.hc;
            coef_loads++;
            return;
        end
        n = vec_len();
        vec_mem[int'(fill_cnt) & (n - 1)] = it.smp;
        fill_cnt = fill_cnt + 1'b1;
        if (int'(fill_cnt) < n && fill_cnt != 0) return;
        fill_cnt = '0;
        vectors_done++;
        taps = (int'(cfg_taps) > TAP_MAX) ? TAP_MAX : int'(cfg_taps);
        for (int j = 0; j < n / 2; j++) begin
            lacc = 0;
            hacc = 0;
            for (int k = 0; k < taps; k++) begin
                // periodic extension: index wraps modulo the vector length
                idx = (2 * j + k - int'(cfg_phase)) & (n - 1);
                lacc += longint'(lp_tap[k]) * longint'(vec_mem[idx]);
                hacc += longint'(hp_tap[k]) * longint'(vec_mem[idx]);
            end
            p.lo   = to_q5_15(lacc);
            p.hi   = to_q5_15(hacc);
            p.idx  = OUT_IDX_W'(j);
            p.last = (j == n / 2 - 1);
            pairs_due.push_back(p);
        end
    endfunction

    function automatic void flag_mismatch(input string what, input longint want,
                                          input longint got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_cnt, what, want, got);
    endfunction

    // result check, then input prediction, then register shadow
    always @(posedge i_clk) begin
        wpair_t want;
        stim_t  got_in;
        if (!i_rst_n) begin
            fill_cnt  = '0;
            cfg_taps  = TAPCNT_RST;
            cfg_phase = PHASE_RST;
            cfg_len   = LEN_RST;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (pairs_due.size() == 0) begin
                    flag_mismatch("unexpected pair, index", -1, longint'(out_ch.out_index));
                end else begin
                    want = pairs_due.pop_front();
                    if (out_ch.low_out !== want.lo)
                        flag_mismatch($sformatf("low_out of pair %0d", want.idx),
                                      longint'(want.lo), longint'(out_ch.low_out));
                    if (out_ch.high_out !== want.hi)
                        flag_mismatch($sformatf("high_out of pair %0d", want.idx),
                                      longint'(want.hi), longint'(out_ch.high_out));
                    if (out_ch.out_index !== want.idx)
                        flag_mismatch("out_index", longint'(want.idx),
                                      longint'(out_ch.out_index));
                    if (out_ch.last_out !== want.last)
                        flag_mismatch($sformatf("last_out of pair %0d", want.idx),
                                      longint'(want.last), longint'(out_ch.last_out));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                got_in.mode = in_ch.mode;
                got_in.ci   = in_ch.coef_index;
                got_in.lc   = in_ch.low_coef;
                got_in.hc   = in_ch.high_coef;
                got_in.smp  = in_ch.sample;
                items_taken++;
                absorb_item(got_in);
            end
            if (i_cfg_we) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_TAP_COUNT:    cfg_taps  = TAPCNT_W'(i_cfg_data);
                    CFG_PHASE_OFFSET: cfg_phase = PHASE_W'(i_cfg_data);
                    CFG_LENGTH_LOG2:  cfg_len   = LEN_W'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // input driver: one transfer per cycle at most, random gaps
    initial begin
        stim_t it;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_COEF;
        in_ch.coef_index <= '0;
        in_ch.low_coef   <= '0;
        in_ch.high_coef  <= '0;
        in_ch.sample     <= '0;
        forever begin
            @(posedge i_clk);
            if (!in_ch.valid || in_ch.ready) begin
                if (i_rst_n && stim_q.size() != 0 &&
                        $urandom_range(99) >= send_idle_pct) begin
                    it = stim_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.mode       <= it.mode;
                    in_ch.coef_index <= it.ci;
                    in_ch.low_coef   <= it.lc;
                    in_ch.high_coef  <= it.hc;
                    in_ch.sample     <= it.smp;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_coef(input int ci, input int lc, input int hc);
        stim_t it;
        it.mode = MODE_COEF;
        it.ci   = COEF_IDX_W'(ci);
        it.lc   = COEF_WIDTH'(lc);
        it.hc   = COEF_WIDTH'(hc);
        it.smp  = SAMPLE_WIDTH'($urandom);
        stim_q.push_back(it);
        items_pushed++;
    endtask

    task automatic push_sample(input int s);
        stim_t it;
        it.mode = MODE_SAMPLE;
        it.ci   = COEF_IDX_W'($urandom);
        it.lc   = COEF_WIDTH'($urandom);
        it.hc   = COEF_WIDTH'($urandom);
        it.smp  = SAMPLE_WIDTH'(s);
        stim_q.push_back(it);
        items_pushed++;
    endtask

    task automatic wait_results_done();
        do @(posedge i_clk);
        while (items_taken != items_pushed || pairs_due.size() != 0);
    endtask

    // registers change only with the block idle
    task automatic set_config(input int taps, input int phase, input int lg);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TAP_COUNT;
        i_cfg_data  <= CFG_DATA_W'(taps);
        @(posedge i_clk);
        i_cfg_index <= CFG_PHASE_OFFSET;
        i_cfg_data  <= CFG_DATA_W'(phase);
        @(posedge i_clk);
        i_cfg_index <= CFG_LENGTH_LOG2;
        i_cfg_data  <= CFG_DATA_W'(lg);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // every tap gets loaded before any vector completes; large magnitudes
    // so that long filters can drive the outputs into saturation
    task automatic test_tap_tables();
        push_coef(0, -32768, 32767);
        for (int k = 1; k < TAP_MAX; k++)
            push_coef(k, -32768 + $urandom_range(4095), 32767 - $urandom_range(4095));
    endtask

    task automatic test_minimum_length();
        set_config(3, 0, 0);   // length code 0 behaves as 1
        push_sample(-32768);
        push_sample(32767);
    endtask

    task automatic test_zero_taps();
        set_config(0, 5, 1);
        push_sample(12345);
        push_sample(-1);
    endtask

    task automatic test_excess_taps_and_offset();
        set_config(63, 63, 2);
        push_sample(32767);
        push_sample(-32768);
        push_sample(0);
        push_sample(1);
    endtask

    task automatic test_saturation();
        set_config(32, 0, 1);
        push_sample(-32768);
        push_sample(-32768);
        push_sample(32767);
        push_sample(32767);
    endtask

    // shrink n after 10 samples of a 16 vector: the next one completes it
    task automatic test_length_cut_mid_fill();
        set_config(4, 1, 4);
        for (int i = 0; i < 10; i++)
            push_sample($urandom);
        set_config(4, 1, 3);
        push_sample($urandom);
    endtask

    task automatic test_random_traffic(input int n_items, input bit long_vectors);
        int done;
        int ph;
        int cnt;
        int coef_pct;
        done = 0;
        ph   = 0;
        while (done < n_items) begin
            coef_pct = 12;
            if (long_vectors && ph == 0) begin
                set_config(32, 0, 7);
                cnt      = 130;
                coef_pct = 0;
            end else if (long_vectors && ph == 1) begin
                set_config(63, 63, 5);
                cnt      = 40;
                coef_pct = 0;
            end else begin
                set_config($urandom_range(63), $urandom_range(63), $urandom_range(4));
                cnt = $urandom_range(4, 28);
            end
            for (int k = 0; k < cnt; k++) begin
                if (ph == 1 && k == cnt / 2)
                    wait_results_done();
                if ($urandom_range(99) < coef_pct)
                    push_coef($urandom_range(TAP_MAX - 1), $urandom, $urandom);
                else
                    push_sample($urandom);
            end
            done += cnt;
            ph++;
        end
    endtask

    initial begin
        send_idle_pct = 34;
        recv_idle_pct = 68;
        items_pushed  = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_TAP_COUNT;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_tap_tables();
        test_minimum_length();
        test_zero_taps();
        test_excess_taps_and_offset();
        test_saturation();
        test_length_cut_mid_fill();
        test_random_traffic(70, 1'b0);

        send_idle_pct = 68;
        recv_idle_pct = 34;
        test_random_traffic(70, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(150, 1'b1);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d items (%0d tap loads), %0d vectors, %0d pairs, %0d reg writes",
                 items_taken, coef_loads, vectors_done, results_seen, cfg_writes);
        $display("lengths 2..128, tap counts 0..63, offsets 0..63, three idle mixes");
        if (mismatch_cnt == 0 && pairs_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d pairs missing", mismatch_cnt, pairs_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
